[src/fdds_pkg.sv]
`timescale 1ns / 1ps

package fdds_pkg;

  localparam int COLUMNS_PER_PANEL_DEFAULT = 28;
  localparam int PANEL_COUNT_DEFAULT = 4;
  localparam int ROW_COUNT_DEFAULT = 16;

  localparam int PULSE_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_TO_BLACK_PULSE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TO_WHITE_PULSE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_FORCE_PULSE = 2'd2;

  localparam logic [PULSE_W-1:0] TO_BLACK_PULSE_RESET = 16'd300;
  localparam logic [PULSE_W-1:0] TO_WHITE_PULSE_RESET = 16'd300;
  localparam logic [PULSE_W-1:0] LONG_FORCE_PULSE_RESET = 16'd1000;

  localparam logic [1:0] COLOUR_BLACK = 2'd0;
  localparam logic [1:0] COLOUR_WHITE = 2'd1;
  localparam logic [1:0] SHADOW_UNKNOWN = 2'd2;

  localparam int CODE_GROUP = 7;

  typedef struct packed {
    logic [6:0] dot_column;
    logic [4:0] dot_row;
    logic [1:0] wanted_colour;
    logic       long_force;
    logic       refresh;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         panel_index;
    logic [4:0]         row_code;
    logic [4:0]         column_code;
    logic               drive_colour;
    logic [PULSE_W-1:0] pulse_us;
  } pulse_t;

  // i + 1 + i/7, never a multiple of 8 for i below 28
  function automatic logic [4:0] address_code(input logic [4:0] i);
    logic [4:0] q;
    q = 5'd0;
    for (int k = 1; k <= 4; k++) begin
      if (i >= 5'(k * CODE_GROUP)) begin
        q = 5'(k);
      end
    end
    return i + 5'd1 + q;
  endfunction

endpackage

[src/fdds_shadow.sv]
`timescale 1ns / 1ps

module fdds_shadow import fdds_pkg::*; #(
  parameter int DEPTH = 1792,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [1:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [1:0]        wr_data,
  output logic              busy
);

  logic [1:0]        mem [DEPTH];
  logic [ADDR_W-1:0] clear_addr;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clear_addr <= '0;
    end else if (busy) begin
      if (clear_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clear_addr] <= SHADOW_UNKNOWN;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // bypass the write landing at the same edge
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

[src/flip_dot_drive_sequencer_top.sv]
`timescale 1ns / 1ps

// Flip-dot drive sequencer. Each accepted command word names one dot; the block
// looks up the dot's known colour in an on-chip shadow map and, when the colour
// is valid and the dot must change (or refresh is set), updates the map and
// sends one drive pulse word with panel, address codes, colour and pulse
// length. A command word can be taken every cycle while cmd_stall is low; the
// shadow is read at the edge that registers the command into stage one, and
// the edge on which stage one fires (output register free) decides, writes
// back and loads the output register. After reset the shadow map is swept to
// unknown, one dot per cycle, over all COLUMNS_PER_PANEL*PANEL_COUNT*ROW_COUNT
// dots (1792 at the defaults), during which cmd_stall stays high; configuration
// writes are taken at any time.
module flip_dot_drive_sequencer_top import fdds_pkg::*; #(
  parameter int COLUMNS_PER_PANEL = COLUMNS_PER_PANEL_DEFAULT,
  parameter int PANEL_COUNT = PANEL_COUNT_DEFAULT,
  parameter int ROW_COUNT = ROW_COUNT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]     cfg_data,
  input  cmd_t                   cmd,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  output pulse_t                 pulse,
  output logic                   pulse_valid,
  input  logic                   pulse_stall
);

  localparam int TOTAL_COLUMNS = COLUMNS_PER_PANEL * PANEL_COUNT;
  localparam int DOT_COUNT = TOTAL_COLUMNS * ROW_COUNT;
  localparam int IDX_W = (DOT_COUNT > 1) ? $clog2(DOT_COUNT) : 1;

  logic [PULSE_W-1:0] to_black_pulse_us;
  logic [PULSE_W-1:0] to_white_pulse_us;
  logic [PULSE_W-1:0] long_force_pulse_us;

  logic             cmd_accept;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;

  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_in_range;
  logic             s1_fire;
  logic             s1_emit;
  logic [1:0]       shadow_q;
  logic             shadow_busy;
  logic             wr_en;
  logic [1:0]       wr_data;
  logic             out_free;
  logic [1:0]       panel;
  logic [4:0]       col_in_panel;
  pulse_t           pulse_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      to_black_pulse_us <= TO_BLACK_PULSE_RESET;
      to_white_pulse_us <= TO_WHITE_PULSE_RESET;
      long_force_pulse_us <= LONG_FORCE_PULSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TO_BLACK_PULSE:   to_black_pulse_us <= cfg_data;
        REG_TO_WHITE_PULSE:   to_white_pulse_us <= cfg_data;
        REG_LONG_FORCE_PULSE: long_force_pulse_us <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !pulse_valid || !pulse_stall;
  assign s1_fire = s1_valid && out_free;
  assign cmd_stall = shadow_busy || (s1_valid && !out_free);
  assign cmd_accept = cmd_valid && !cmd_stall;

  always_comb begin
    in_range = (int'(cmd.dot_column) < TOTAL_COLUMNS) && (int'(cmd.dot_row) < ROW_COUNT);
    if (in_range) begin
      in_idx = IDX_W'(int'(cmd.dot_row) * TOTAL_COLUMNS + int'(cmd.dot_column));
    end else begin
      in_idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1_cmd <= cmd;
      s1_idx <= in_idx;
      s1_in_range <= in_range;
    end
  end

  fdds_shadow #(
    .DEPTH  (DOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_shadow (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd_accept),
    .rd_addr (in_idx),
    .rd_data (shadow_q),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (wr_data),
    .busy    (shadow_busy)
  );

  // refresh acts before the colour check
  always_comb begin
    s1_emit = s1_in_range && (s1_cmd.wanted_colour <= COLOUR_WHITE) &&
              (s1_cmd.refresh || (shadow_q != s1_cmd.wanted_colour));
    wr_en = s1_fire && s1_in_range && (s1_cmd.refresh || s1_emit);
    wr_data = s1_emit ? s1_cmd.wanted_colour : SHADOW_UNKNOWN;
  end

  always_comb begin
    panel = 2'd0;
    for (int p = 1; p < PANEL_COUNT; p++) begin
      if (int'(s1_cmd.dot_column) >= p * COLUMNS_PER_PANEL) begin
        panel = 2'(p);
      end
    end
    col_in_panel = 5'(int'(s1_cmd.dot_column) - int'(panel) * COLUMNS_PER_PANEL);
    pulse_next.panel_index = panel;
    pulse_next.row_code = address_code(s1_cmd.dot_row);
    pulse_next.column_code = address_code(col_in_panel);
    pulse_next.drive_colour = s1_cmd.wanted_colour[0];
    if (s1_cmd.long_force) begin
      pulse_next.pulse_us = long_force_pulse_us;
    end else if (s1_cmd.wanted_colour == COLOUR_BLACK) begin
      pulse_next.pulse_us = to_black_pulse_us;
    end else begin
      pulse_next.pulse_us = to_white_pulse_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (out_free) begin
      pulse_valid <= s1_fire && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      pulse <= pulse_next;
    end
  end

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_cmd) && $stable(s1_idx)))
    else $error("stage one lost its command while blocked");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    shadow_busy |-> (!s1_valid && !pulse_valid))
    else $error("command in flight during shadow clearing");

  a_pulse_from_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_emit) |=> (pulse_valid &&
      (pulse.drive_colour == $past(s1_cmd.wanted_colour[0]))))
    else $error("emitted command did not reach the output register");

  a_write_matches_emit: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_emit) |-> (wr_en && (wr_data == s1_cmd.wanted_colour)))
    else $error("shadow not updated for driven dot");

endmodule
